// ===== rtl/trem_pkg.sv =====
// Package for the tremolo volume modulator.
// Word types of both channels, register indexes and datapath widths.
// No dependencies.
package trem_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 1024;
	localparam int PHASE_BITS_DEF       = 16;

	localparam int TONE_W  = 32;
	localparam int VOL_W   = 8;
	localparam int AMP_W   = 10;
	localparam int RAMP_W  = 16;
	localparam int STEP_W  = 16;
	localparam int SINE_W  = 16;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 2;

	localparam int VA_W       = VOL_W + AMP_W;
	localparam int RS_W       = 32;
	localparam int PROD_W     = RS_W + VA_W;
	localparam int RND_SHIFT  = 23;
	localparam int DQ_W       = 11;
	localparam int DIV_W      = RAMP_W;
	localparam int MAG_W      = RND_SHIFT + 1 + DQ_W + DIV_W;
	localparam int SUM_W      = DQ_W + 2;

	localparam logic [VOL_W-1:0] VOL_MAX = 8'd255;

	localparam logic [AMP_W-1:0]  AMP_RESET  = 10'd128;
	localparam logic [RAMP_W-1:0] RAMP_RESET = 16'd0;
	localparam logic [STEP_W-1:0] STEP_RESET = 16'd1043;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CIDX_W-1:0] {
		REG_AMPLITUDE = 2'd0,
		REG_RAMP      = 2'd1,
		REG_STEP      = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [TONE_W-1:0] tone_word;
		logic [VOL_W-1:0]  volume_in;
	} in_word_t;

	typedef struct packed {
		logic [VOL_W-1:0] volume_out;
		logic             clipped;
		logic             zeroed;
	} out_word_t;

endpackage

// ===== rtl/tremolo_volume_modulator.sv =====
// Tremolo volume modulator top level: sine LFO applied to one volume per frame.
// Uses trem_pkg for word types, register indexes and widths.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one frame word, tone code and volume.
//   out channel (out_valid/out_ready/out_data): one result word per frame,
//   modulated volume saturated to 0..255 with clip and zero flags.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; write only while no frame is in flight. Index 3 is ignored.
// Timing:
//   A frame runs through a sequencer around one shared 32x18 multiplier and a
//   one-bit-per-cycle restoring divider: ROM read, three multiplies, a rounding
//   add, 11 divide steps and a saturation step. out_valid is registered when
//   the saturation step finds the output slot free. A new frame is accepted
//   only after the last has left that step; the divide steps are most of a run.
// Reset:
//   arst_n clears the ramp, the phase and the frame history and loads the
//   register defaults; the first frame always restarts the ramp.
// Stall:
//   the result stays in the output register while out_ready is low; the next
//   frame may already be accepted and waits in its final step for the slot.
module tremolo_volume_modulator #(
	parameter int SINE_TABLE_DEPTH = trem_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int PHASE_BITS       = trem_pkg::PHASE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  trem_pkg::in_word_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output trem_pkg::out_word_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [trem_pkg::CIDX_W-1:0] cfg_index,
	input  logic [trem_pkg::CFG_W-1:0]  cfg_data
);

	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int IPR_W  = PHASE_BITS + IDX_W + 1;
	localparam int ROM_W  = SINE_TABLE_DEPTH * trem_pkg::SINE_W;
	localparam int CNT_W  = $clog2(trem_pkg::DQ_W);

	// sin(pi/2 * r / depth) in Q1.15, 9-term Taylor series in Q30
	function automatic logic [trem_pkg::SINE_W-1:0] quarter_sine(input logic [63:0] r);
		logic [63:0] x;
		logic [63:0] t;
		longint      sum;
		logic [63:0] q;
		x = (trem_pkg::HALF_PI_Q30 * r) / SINE_TABLE_DEPTH;
		t = x;
		sum = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			t = (t * x) >> 30;
			t = (t * x) >> 30;
			t = t / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - longint'(t);
			end else begin
				sum = sum + longint'(t);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		q = (64'(sum) + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[trem_pkg::SINE_W-1:0];
	endfunction

	function automatic logic [ROM_W-1:0] build_rom();
		logic [ROM_W-1:0]            rom;
		logic [63:0]                 p;
		logic [63:0]                 quad;
		logic [63:0]                 r;
		logic [trem_pkg::SINE_W-1:0] mag;
		rom = '0;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			p = 64'(4 * i);
			quad = p / SINE_TABLE_DEPTH;
			r = p % SINE_TABLE_DEPTH;
			if (quad[0]) begin
				mag = quarter_sine(64'(SINE_TABLE_DEPTH) - r);
			end else begin
				mag = quarter_sine(r);
			end
			if (quad >= 64'd2) begin
				rom[i*trem_pkg::SINE_W +: trem_pkg::SINE_W] = -mag;
			end else begin
				rom[i*trem_pkg::SINE_W +: trem_pkg::SINE_W] = mag;
			end
		end
		return rom;
	endfunction

	localparam logic [ROM_W-1:0] SINE_ROM = build_rom();

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_ROM    = 8'b0000_0010,
		ST_MUL_VA = 8'b0000_0100,
		ST_MUL_RS = 8'b0000_1000,
		ST_MUL_P  = 8'b0001_0000,
		ST_ADJ    = 8'b0010_0000,
		ST_DIV    = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [trem_pkg::AMP_W-1:0]  amp_q;
	logic [trem_pkg::RAMP_W-1:0] ramp_q;
	logic [trem_pkg::STEP_W-1:0] step_q;

	logic [trem_pkg::TONE_W-1:0] prev_tone_q;
	logic [trem_pkg::VOL_W-1:0]  prev_vol_q;
	logic                        hist_q;
	logic [trem_pkg::RAMP_W-1:0] rc_q;
	logic [PHASE_BITS-1:0]       phase_q;

	logic [IDX_W-1:0]             idx_q;
	logic [trem_pkg::VOL_W-1:0]   vol_q;
	logic [trem_pkg::SINE_W-1:0]  sine_q;
	logic [trem_pkg::VA_W-1:0]    va_q;
	logic [trem_pkg::RS_W-1:0]    rs_q;
	logic [trem_pkg::PROD_W-1:0]  prod_q;
	logic [trem_pkg::DIV_W-1:0]   rem_q;
	logic [trem_pkg::DQ_W-1:0]    dq_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         out_valid_q;
	trem_pkg::out_word_t          out_q;

	logic                         restart;
	logic [IPR_W-1:0]             idx_prod;
	logic [PHASE_BITS+15:0]       step_wide;
	logic                         full;
	logic [trem_pkg::RAMP_W-1:0]  rc_eff;
	logic [trem_pkg::DIV_W-1:0]   rdiv;
	logic                         sneg;
	logic [trem_pkg::SINE_W-1:0]  sabs;
	logic [trem_pkg::RS_W-1:0]    mul_a;
	logic [trem_pkg::VA_W-1:0]    mul_b;
	logic [trem_pkg::PROD_W-1:0]  mul_p;
	logic [trem_pkg::MAG_W-1:0]   p2;
	logic [trem_pkg::MAG_W-1:0]   kbias;
	logic [trem_pkg::MAG_W-1:0]   mag;
	logic [trem_pkg::DIV_W:0]     div_num;
	logic                         div_ge;
	logic [trem_pkg::DIV_W:0]     div_diff;
	logic signed [trem_pkg::SUM_W-1:0] delta;
	logic signed [trem_pkg::SUM_W-1:0] vsum;
	logic                         slot_free;
	trem_pkg::out_word_t          res;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign restart = !hist_q || (in_data.tone_word != prev_tone_q)
		|| (in_data.volume_in != prev_vol_q);

	assign idx_prod  = IPR_W'(phase_q) * IPR_W'(SINE_TABLE_DEPTH);
	assign step_wide = {step_q, PHASE_BITS'(0)};

	assign full   = (rc_q >= ramp_q);
	assign rc_eff = full ? trem_pkg::RAMP_W'(1) : rc_q;
	assign rdiv   = full ? trem_pkg::DIV_W'(1) : ramp_q;

	assign sneg = sine_q[trem_pkg::SINE_W-1];
	assign sabs = sneg ? -sine_q : sine_q;

	// shared multiplier
	always_comb begin
		unique case (state_q)
			ST_MUL_VA: begin
				mul_a = trem_pkg::RS_W'(vol_q);
				mul_b = trem_pkg::VA_W'(amp_q);
			end
			ST_MUL_RS: begin
				mul_a = trem_pkg::RS_W'(sabs);
				mul_b = trem_pkg::VA_W'(rc_eff);
			end
			ST_MUL_P: begin
				mul_a = rs_q;
				mul_b = va_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = trem_pkg::PROD_W'(mul_a) * trem_pkg::PROD_W'(mul_b);

	// x + 0.5 as a magnitude, scaled by 2^(RND_SHIFT+1)
	assign p2    = {prod_q, 1'b0};
	assign kbias = trem_pkg::MAG_W'({rdiv, trem_pkg::RND_SHIFT'(0)});
	always_comb begin
		if (sneg) begin
			mag = (p2 > kbias) ? (p2 - kbias) : '0;
		end else begin
			mag = p2 + kbias;
		end
	end

	assign div_num  = {rem_q, dq_q[trem_pkg::DQ_W-1]};
	assign div_ge   = (div_num >= {1'b0, rdiv});
	assign div_diff = div_num - {1'b0, rdiv};

	assign delta = sneg ? -trem_pkg::SUM_W'(dq_q) : trem_pkg::SUM_W'(dq_q);
	assign vsum  = trem_pkg::SUM_W'(vol_q) + delta;

	always_comb begin
		res.volume_out = vsum[trem_pkg::VOL_W-1:0];
		res.clipped    = 1'b0;
		res.zeroed     = 1'b0;
		if (vsum > $signed(trem_pkg::SUM_W'(trem_pkg::VOL_MAX))) begin
			res.volume_out = trem_pkg::VOL_MAX;
			res.clipped    = 1'b1;
		end
		if (vsum < 0) begin
			res.volume_out = '0;
			res.zeroed     = 1'b1;
		end
	end

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q  <= trem_pkg::AMP_RESET;
			ramp_q <= trem_pkg::RAMP_RESET;
			step_q <= trem_pkg::STEP_RESET;
		end else if (cfg_valid) begin
			unique case (trem_pkg::reg_index_t'(cfg_index))
				trem_pkg::REG_AMPLITUDE: amp_q <= cfg_data[trem_pkg::AMP_W-1:0];
				trem_pkg::REG_RAMP:      ramp_q <= cfg_data[trem_pkg::RAMP_W-1:0];
				trem_pkg::REG_STEP:      step_q <= cfg_data[trem_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_tone_q <= '0;
			prev_vol_q  <= '0;
			hist_q      <= 1'b0;
			rc_q        <= '0;
			phase_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (restart) begin
							rc_q <= '0;
						end
						prev_tone_q <= in_data.tone_word;
						prev_vol_q  <= in_data.volume_in;
						hist_q      <= 1'b1;
						phase_q     <= phase_q + step_wide[PHASE_BITS+15:16];
						state_q     <= ST_ROM;
					end
				end
				ST_ROM:    state_q <= ST_MUL_VA;
				ST_MUL_VA: state_q <= ST_MUL_RS;
				ST_MUL_RS: state_q <= ST_MUL_P;
				ST_MUL_P:  state_q <= ST_ADJ;
				ST_ADJ: begin
					cnt_q   <= CNT_W'(trem_pkg::DQ_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						if (rc_q < ramp_q) begin
							rc_q <= rc_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			idx_q <= idx_prod[PHASE_BITS +: IDX_W];
			vol_q <= in_data.volume_in;
		end
		if (state_q == ST_ROM) begin
			sine_q <= SINE_ROM[32'(idx_q) * trem_pkg::SINE_W +: trem_pkg::SINE_W];
		end
		if (state_q == ST_MUL_VA) begin
			va_q <= mul_p[trem_pkg::VA_W-1:0];
		end
		if (state_q == ST_MUL_RS) begin
			rs_q <= mul_p[trem_pkg::RS_W-1:0];
		end
		if (state_q == ST_MUL_P) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_ADJ) begin
			rem_q <= mag[trem_pkg::MAG_W-1 -: trem_pkg::DIV_W];
			dq_q  <= mag[trem_pkg::RND_SHIFT+1 +: trem_pkg::DQ_W];
		end
		if (state_q == ST_DIV) begin
			rem_q <= div_ge ? div_diff[trem_pkg::DIV_W-1:0] : div_num[trem_pkg::DIV_W-1:0];
			dq_q  <= {dq_q[trem_pkg::DQ_W-2:0], div_ge};
		end
		if (state_q == ST_DONE && slot_free) begin
			out_q <= res;
		end
	end

endmodule
